// ===== rtl/aabbcr_pkg.sv =====
// ----------------------------------------------------------------------------
// aabbcr_pkg
// Shared types and constants of the box collision push resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package aabbcr_pkg;

  localparam int FORCE_W  = 16;
  localparam int DIV_W    = FORCE_W + 1;
  localparam int MARGIN_W = 8;
  localparam int DIR_W    = 4;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd1;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE         = 4'd0,
    DIR_TOP          = 4'd1,
    DIR_BOTTOM       = 4'd2,
    DIR_LEFT         = 4'd3,
    DIR_RIGHT        = 4'd4,
    DIR_TOP_LEFT     = 4'd5,
    DIR_TOP_RIGHT    = 4'd6,
    DIR_BOTTOM_LEFT  = 4'd7,
    DIR_BOTTOM_RIGHT = 4'd8
  } dir_t;

endpackage

`default_nettype wire

// ===== rtl/aabbcr_if.sv =====
// ----------------------------------------------------------------------------
// aabbcr channel interfaces
// Valid/ready channels for box pair items and for resolved push items.
// ----------------------------------------------------------------------------
`default_nettype none

interface aabbcr_pair_if #(
  parameter int COORD_BITS = 24
);
  logic                                valid;
  logic                                ready;
  logic signed [COORD_BITS-1:0]        a_left;
  logic signed [COORD_BITS-1:0]        a_top;
  logic [COORD_BITS-2:0]               a_width;
  logic [COORD_BITS-2:0]               a_height;
  logic signed [COORD_BITS-1:0]        a_move_x;
  logic signed [COORD_BITS-1:0]        a_move_y;
  logic signed [COORD_BITS-1:0]        b_left;
  logic signed [COORD_BITS-1:0]        b_top;
  logic [COORD_BITS-2:0]               b_width;
  logic [COORD_BITS-2:0]               b_height;
  logic [aabbcr_pkg::FORCE_W-1:0]      push_force;
  logic [aabbcr_pkg::FORCE_W-1:0]      b_resistance;

  modport source (
    output valid, a_left, a_top, a_width, a_height, a_move_x, a_move_y,
           b_left, b_top, b_width, b_height, push_force, b_resistance,
    input  ready
  );
  modport sink (
    input  valid, a_left, a_top, a_width, a_height, a_move_x, a_move_y,
           b_left, b_top, b_width, b_height, push_force, b_resistance,
    output ready
  );
endinterface

interface aabbcr_res_if #(
  parameter int COORD_BITS = 24
);
  logic                              valid;
  logic                              ready;
  logic [aabbcr_pkg::DIR_W-1:0]      direction;
  logic signed [COORD_BITS:0]        a_shift_x;
  logic signed [COORD_BITS:0]        a_shift_y;
  logic signed [COORD_BITS:0]        b_shift_x;
  logic signed [COORD_BITS:0]        b_shift_y;

  modport source (
    output valid, direction, a_shift_x, a_shift_y, b_shift_x, b_shift_y,
    input  ready
  );
  modport sink (
    input  valid, direction, a_shift_x, a_shift_y, b_shift_x, b_shift_y,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/aabbcr_div.sv =====
// ----------------------------------------------------------------------------
// aabbcr_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module aabbcr_div #(
  parameter int QW = 25
) (
  input  wire                               clk,
  input  wire                               en,
  input  wire [aabbcr_pkg::DIV_W-2:0]       num_hi,
  input  wire [QW-1:0]                      num_lo,
  input  wire [aabbcr_pkg::DIV_W-1:0]       den,
  output logic [QW-1:0]                     quo
);
  localparam int DW = aabbcr_pkg::DIV_W;

  // The upper numerator part is below the divisor, so it seeds the remainder.
  logic [DW-1:0] rem [QW];
  logic [QW-1:0] sh  [QW];
  logic [DW-1:0] dv  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] sh_in;
    logic [DW-1:0] dv_in;
    logic [DW:0]   trial;
    logic          qbit;

    if (k == 0) begin : g_first
      assign rem_in = {1'b0, num_hi};
      assign sh_in  = num_lo;
      assign dv_in  = den;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign sh_in  = sh[k-1];
      assign dv_in  = dv[k-1];
    end

    assign trial = {rem_in, sh_in[QW-1]};
    assign qbit  = (trial >= {1'b0, dv_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= qbit ? DW'(trial - {1'b0, dv_in}) : trial[DW-1:0];
        sh[k]  <= {sh_in[QW-2:0], qbit};
        dv[k]  <= dv_in;
      end
    end
  end

  assign quo = sh[QW-1];

endmodule

`default_nettype wire

// ===== rtl/aabb_collision_push_resolve_core.sv =====
// ----------------------------------------------------------------------------
// aabb_collision_push_resolve_core
// Classifies a fresh hit of a moving box against a second box and splits the
// push-out shift between the two boxes by force and resistance.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake     Carries
//   pair      in         valid/ready   box A, its motion, box B, force, resistance
//   res       out        valid/ready   direction and the four saturated shifts
//   cfg       in         cfg_we        push_margin, 8 bits, reset value 1
//
// One item enters in every cycle unless the output stalls. An item passes
// four stages for edges, classification, penetration and multiply, then
// COORD_BITS + 1 divider stages (one quotient bit each), then the result
// register. The whole pipe advances together unless a result waits at the
// output; a stall freezes every stage, so nothing is lost or repeated.
// Reset (synchronous, active high) clears the valid bits and sets push_margin
// back to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_collision_push_resolve_core #(
  parameter int COORD_BITS = 24
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire [aabbcr_pkg::MARGIN_W-1:0]        cfg_wdata,
  aabbcr_pair_if.sink                           pair,
  aabbcr_res_if.source                          res
);
  localparam int EW = COORD_BITS + 3;                // edge and difference width
  localparam int PW = COORD_BITS + 1;                // penetration magnitude width
  localparam int NW = PW + aabbcr_pkg::FORCE_W;      // penetration times force
  localparam int SW = COORD_BITS + 1;                // output shift width
  localparam int FW = aabbcr_pkg::FORCE_W;
  localparam int DW = aabbcr_pkg::DIV_W;

  localparam logic [PW:0] POS_MAX = {2'b00, {COORD_BITS{1'b1}}};
  localparam logic [PW:0] NEG_MAG = {2'b01, {COORD_BITS{1'b0}}};

  typedef struct {
    logic signed [EW-1:0] l;
    logic signed [EW-1:0] t;
    logic signed [EW-1:0] r;
    logic signed [EW-1:0] b;
  } box_t;

  typedef struct packed {
    logic [PW-1:0] pen_x;
    logic [PW-1:0] pen_y;
    logic          x_on;
    logic          x_pos;
    logic          y_on;
    logic          y_pos;
    logic          hard_push;
    logic [aabbcr_pkg::DIR_W-1:0] dir;
  } side_t;

  function automatic logic between(logic signed [EW-1:0] lo, logic signed [EW-1:0] x,
                                   logic signed [EW-1:0] hi);
    return (lo <= x) && (x <= hi);
  endfunction

  // Boxes meet when they are not separated and a corner of one lies inside
  // the other, edges included.
  function automatic logic meets(box_t p, box_t q);
    logic sep;
    logic c1, c2, c3, c4;
    sep = (p.r < q.l) || (q.r < p.l) || (p.b < q.t) || (q.b < p.t);
    c1  = (between(p.l, q.r, p.r) && between(p.t, q.b, p.b)) ||
          (between(q.l, p.l, q.r) && between(q.t, p.t, q.b));
    c2  = (between(p.l, q.l, p.r) && between(p.t, q.b, p.b)) ||
          (between(q.l, p.r, q.r) && between(q.t, p.t, q.b));
    c3  = (between(p.l, q.r, p.r) && between(p.t, q.t, p.b)) ||
          (between(q.l, p.l, q.r) && between(q.t, p.b, q.b));
    c4  = (between(p.l, q.l, p.r) && between(p.t, q.t, p.b)) ||
          (between(q.l, p.r, q.r) && between(q.t, p.b, q.b));
    return !sep && (c1 || c2 || c3 || c4);
  endfunction

  function automatic logic [SW-1:0] sat_pos(logic [PW:0] v);
    return (v > POS_MAX) ? POS_MAX[SW-1:0] : v[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] sat_neg(logic [PW:0] v);
    return (v > NEG_MAG) ? NEG_MAG[SW-1:0] : SW'(-v[SW-1:0]);
  endfunction

  // The pipe moves as one whenever the output register is free or drained.
  logic en;
  logic out_valid;
  assign en = !out_valid || res.ready;
  assign pair.ready = en;

  logic [aabbcr_pkg::MARGIN_W-1:0] margin;
  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= aabbcr_pkg::MARGIN_RESET;
    end else if (cfg_we) begin
      margin <= cfg_wdata;
    end
  end

  // Stage 1: current, previous and target box edges.
  logic          v1;
  box_t          a1, o1, b1;
  logic [FW-1:0] f1, r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1.l <= EW'(pair.a_left);
      a1.t <= EW'(pair.a_top);
      a1.r <= EW'(pair.a_left) + EW'($signed({1'b0, pair.a_width}));
      a1.b <= EW'(pair.a_top) + EW'($signed({1'b0, pair.a_height}));
      o1.l <= EW'(pair.a_left) - EW'(pair.a_move_x);
      o1.t <= EW'(pair.a_top) - EW'(pair.a_move_y);
      o1.r <= EW'(pair.a_left) + EW'($signed({1'b0, pair.a_width}))
              - EW'(pair.a_move_x);
      o1.b <= EW'(pair.a_top) + EW'($signed({1'b0, pair.a_height}))
              - EW'(pair.a_move_y);
      b1.l <= EW'(pair.b_left);
      b1.t <= EW'(pair.b_top);
      b1.r <= EW'(pair.b_left) + EW'($signed({1'b0, pair.b_width}));
      b1.b <= EW'(pair.b_top) + EW'($signed({1'b0, pair.b_height}));
      f1   <= pair.push_force;
      r1   <= pair.b_resistance;
    end
  end

  // Stage 2: hit test and direction, with corner ties left for stage 3.
  aabbcr_pkg::dir_t dir2_next, dir2;
  logic             tie2_next, tie2;
  logic             v2;
  logic signed [EW-1:0] pl2, pr2, pt2, pb2;
  logic [FW-1:0]    f2, r2;

  always_comb begin
    logic xin, yin;
    xin = ((b1.l <= o1.l) && (o1.r <= b1.r)) || ((o1.l <= b1.l) && (b1.r <= o1.r));
    yin = ((b1.t <= o1.t) && (o1.b <= b1.b)) || ((o1.t <= b1.t) && (b1.b <= o1.b));
    tie2_next = 1'b0;
    dir2_next = aabbcr_pkg::DIR_NONE;
    if (!meets(a1, b1) || meets(o1, b1)) begin
      dir2_next = aabbcr_pkg::DIR_NONE;
    end else if (xin && (b1.b < o1.t)) begin
      dir2_next = aabbcr_pkg::DIR_TOP;
    end else if (xin && (o1.b < b1.t)) begin
      dir2_next = aabbcr_pkg::DIR_BOTTOM;
    end else if (yin && (b1.r < o1.l)) begin
      dir2_next = aabbcr_pkg::DIR_LEFT;
    end else if (yin && (o1.r < b1.l)) begin
      dir2_next = aabbcr_pkg::DIR_RIGHT;
    end else if ((b1.l < o1.l) && (b1.t < o1.t)) begin
      if (o1.l <= b1.r) begin
        dir2_next = aabbcr_pkg::DIR_TOP;
      end else if (o1.t <= b1.b) begin
        dir2_next = aabbcr_pkg::DIR_LEFT;
      end else begin
        dir2_next = aabbcr_pkg::DIR_TOP_LEFT;
        tie2_next = 1'b1;
      end
    end else if ((o1.r < b1.r) && (b1.t < o1.t)) begin
      if (b1.l <= o1.r) begin
        dir2_next = aabbcr_pkg::DIR_TOP;
      end else if (o1.t <= b1.b) begin
        dir2_next = aabbcr_pkg::DIR_RIGHT;
      end else begin
        dir2_next = aabbcr_pkg::DIR_TOP_RIGHT;
        tie2_next = 1'b1;
      end
    end else if ((b1.l < o1.l) && (o1.b < b1.b)) begin
      if (o1.l <= b1.r) begin
        dir2_next = aabbcr_pkg::DIR_BOTTOM;
      end else if (b1.t <= o1.b) begin
        dir2_next = aabbcr_pkg::DIR_LEFT;
      end else begin
        dir2_next = aabbcr_pkg::DIR_BOTTOM_LEFT;
        tie2_next = 1'b1;
      end
    end else if ((o1.r < b1.r) && (o1.b < b1.b)) begin
      if (b1.l <= o1.r) begin
        dir2_next = aabbcr_pkg::DIR_BOTTOM;
      end else if (b1.t <= o1.b) begin
        dir2_next = aabbcr_pkg::DIR_RIGHT;
      end else begin
        dir2_next = aabbcr_pkg::DIR_BOTTOM_RIGHT;
        tie2_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir2 <= dir2_next;
      tie2 <= tie2_next;
      pl2  <= b1.r - a1.l;
      pr2  <= a1.r - b1.l;
      pt2  <= b1.b - a1.t;
      pb2  <= a1.b - b1.t;
      f2   <= f1;
      r2   <= r1;
    end
  end

  // Stage 3: corner tie-break by depth, penetration select and clamp.
  aabbcr_pkg::dir_t dir3_next;
  side_t            side3_next, side3;
  logic             v3;
  logic [FW-1:0]    f3;
  logic [DW-1:0]    d3;

  always_comb begin
    logic signed [EW-1:0] dx, dy, sel_x, sel_y;
    logic up_side, left_side;
    up_side   = (dir2 == aabbcr_pkg::DIR_TOP_LEFT) || (dir2 == aabbcr_pkg::DIR_TOP_RIGHT);
    left_side = (dir2 == aabbcr_pkg::DIR_TOP_LEFT) || (dir2 == aabbcr_pkg::DIR_BOTTOM_LEFT);
    dx = left_side ? pl2 : pr2;
    dy = up_side ? pt2 : pb2;
    dir3_next = dir2;
    if (tie2) begin
      if (dx > dy) begin
        dir3_next = up_side ? aabbcr_pkg::DIR_TOP : aabbcr_pkg::DIR_BOTTOM;
      end else if (dx < dy) begin
        dir3_next = left_side ? aabbcr_pkg::DIR_LEFT : aabbcr_pkg::DIR_RIGHT;
      end
    end

    side3_next.y_on  = 1'b0;
    side3_next.y_pos = 1'b0;
    side3_next.x_on  = 1'b0;
    side3_next.x_pos = 1'b0;
    case (dir3_next)
      aabbcr_pkg::DIR_TOP, aabbcr_pkg::DIR_TOP_LEFT, aabbcr_pkg::DIR_TOP_RIGHT: begin
        side3_next.y_on  = 1'b1;
        side3_next.y_pos = 1'b1;
      end
      aabbcr_pkg::DIR_BOTTOM, aabbcr_pkg::DIR_BOTTOM_LEFT,
      aabbcr_pkg::DIR_BOTTOM_RIGHT: begin
        side3_next.y_on  = 1'b1;
      end
      default: begin
      end
    endcase
    case (dir3_next)
      aabbcr_pkg::DIR_LEFT, aabbcr_pkg::DIR_TOP_LEFT, aabbcr_pkg::DIR_BOTTOM_LEFT: begin
        side3_next.x_on  = 1'b1;
        side3_next.x_pos = 1'b1;
      end
      aabbcr_pkg::DIR_RIGHT, aabbcr_pkg::DIR_TOP_RIGHT,
      aabbcr_pkg::DIR_BOTTOM_RIGHT: begin
        side3_next.x_on  = 1'b1;
      end
      default: begin
      end
    endcase

    // Penetration is never negative after a hit; it is clamped to zero anyway.
    sel_y = side3_next.y_pos ? pt2 : pb2;
    sel_x = side3_next.x_pos ? pl2 : pr2;
    side3_next.pen_y     = (sel_y[EW-1] || !side3_next.y_on) ? '0 : sel_y[PW-1:0];
    side3_next.pen_x     = (sel_x[EW-1] || !side3_next.x_on) ? '0 : sel_x[PW-1:0];
    side3_next.hard_push = (f2 > r2);
    side3_next.dir       = dir3_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= side3_next;
      f3    <= f2;
      d3    <= DW'(f2) + DW'(r2);
    end
  end

  // Stage 4: penetration times force for both axes.
  side_t         side4;
  logic          v4;
  logic [NW-1:0] prod_x4, prod_y4;
  logic [DW-1:0] d4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4   <= side3;
      d4      <= d3;
      prod_x4 <= NW'(side3.pen_x) * NW'(f3);
      prod_y4 <= NW'(side3.pen_y) * NW'(f3);
    end
  end

  // Divider stages: B's share is floor(pen * force / (force + resistance)).
  logic [PW-1:0] quo_x, quo_y;

  aabbcr_div #(.QW(PW)) u_div_x (
    .clk    (clk),
    .en     (en),
    .num_hi (prod_x4[NW-1:PW]),
    .num_lo (prod_x4[PW-1:0]),
    .den    (d4),
    .quo    (quo_x)
  );

  aabbcr_div #(.QW(PW)) u_div_y (
    .clk    (clk),
    .en     (en),
    .num_hi (prod_y4[NW-1:PW]),
    .num_lo (prod_y4[PW-1:0]),
    .den    (d4),
    .quo    (quo_y)
  );

  // Side information rides a delay line matched to the divider depth.
  side_t        side_dl [PW];
  logic [PW-1:0] v_dl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_dl <= '0;
    end else if (en) begin
      v_dl <= {v_dl[PW-2:0], v4};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_dl[0] <= side4;
      for (int k = 1; k < PW; k++) begin
        side_dl[k] <= side_dl[k-1];
      end
    end
  end

  // Output stage: A takes the rest plus the margin; both shifts saturate.
  side_t         sd;
  logic [PW-1:0] bs_x, bs_y;
  logic [PW:0]   am_x, am_y;

  assign sd   = side_dl[PW-1];
  assign bs_x = sd.hard_push ? quo_x : '0;
  assign bs_y = sd.hard_push ? quo_y : '0;
  assign am_x = {1'b0, sd.pen_x} - {1'b0, bs_x} + (PW+1)'(margin);
  assign am_y = {1'b0, sd.pen_y} - {1'b0, bs_y} + (PW+1)'(margin);

  logic [aabbcr_pkg::DIR_W-1:0] dir_q;
  logic [SW-1:0]                 ax_q, ay_q, bx_q, by_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_dl[PW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_q <= sd.dir;
      ax_q  <= !sd.x_on ? '0 : (sd.x_pos ? sat_pos(am_x) : sat_neg(am_x));
      bx_q  <= !sd.x_on ? '0 : (sd.x_pos ? sat_neg({1'b0, bs_x})
                                         : sat_pos({1'b0, bs_x}));
      ay_q  <= !sd.y_on ? '0 : (sd.y_pos ? sat_pos(am_y) : sat_neg(am_y));
      by_q  <= !sd.y_on ? '0 : (sd.y_pos ? sat_neg({1'b0, bs_y})
                                         : sat_pos({1'b0, bs_y}));
    end
  end

  assign res.valid     = out_valid;
  assign res.direction = dir_q;
  assign res.a_shift_x = ax_q;
  assign res.a_shift_y = ay_q;
  assign res.b_shift_x = bx_q;
  assign res.b_shift_y = by_q;

endmodule

`default_nettype wire

// ===== bench/aabb_collision_push_resolve_core_chk.sv =====
// ----------------------------------------------------------------------------
// aabb_collision_push_resolve_core_chk
// Watches the pair and result channels, predicts each push item and compares.
// ----------------------------------------------------------------------------
module aabb_collision_push_resolve_core_chk #(
  parameter int CB = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [aabbcr_pkg::MARGIN_W-1:0] cfg_wdata,
  aabbcr_pair_if                          pair,
  aabbcr_res_if                           res,
  output int                              fails,
  output int                              pending
);

  typedef struct packed {
    logic [aabbcr_pkg::DIR_W-1:0] dir;
    logic [CB:0]                  ax, ay, bx, by;
  } push_t;

  typedef struct {
    longint l, t, r, b;
  } rect_t;

  push_t                           push_q[$];
  logic [aabbcr_pkg::MARGIN_W-1:0] margin;

  assign pending = push_q.size();

  function automatic bit between(longint lo, longint x, longint hi);
    return lo <= x && x <= hi;
  endfunction

  function automatic bit touches(rect_t p, rect_t q);
    if (p.r < q.l || q.r < p.l || p.b < q.t || q.b < p.t) return 0;
    return (between(p.l, q.r, p.r) && between(p.t, q.b, p.b)) ||
           (between(q.l, p.l, q.r) && between(q.t, p.t, q.b)) ||
           (between(p.l, q.l, p.r) && between(p.t, q.b, p.b)) ||
           (between(q.l, p.r, q.r) && between(q.t, p.t, q.b)) ||
           (between(p.l, q.r, p.r) && between(p.t, q.t, p.b)) ||
           (between(q.l, p.l, q.r) && between(q.t, p.b, q.b)) ||
           (between(p.l, q.l, p.r) && between(p.t, q.t, p.b)) ||
           (between(q.l, p.r, q.r) && between(q.t, p.b, q.b));
  endfunction

  function automatic aabbcr_pkg::dir_t hit_dir(rect_t a, rect_t o, rect_t b);
    longint dx, dy;
    if (!touches(a, b) || touches(o, b)) return aabbcr_pkg::DIR_NONE;
    if ((b.l <= o.l && o.r <= b.r) || (o.l <= b.l && b.r <= o.r)) begin
      if (b.b < o.t) return aabbcr_pkg::DIR_TOP;
      if (o.b < b.t) return aabbcr_pkg::DIR_BOTTOM;
    end
    if ((b.t <= o.t && o.b <= b.b) || (o.t <= b.t && b.b <= o.b)) begin
      if (b.r < o.l) return aabbcr_pkg::DIR_LEFT;
      if (o.r < b.l) return aabbcr_pkg::DIR_RIGHT;
    end
    if (b.l < o.l && b.t < o.t) begin
      if (o.l <= b.r) return aabbcr_pkg::DIR_TOP;
      if (o.t <= b.b) return aabbcr_pkg::DIR_LEFT;
      dx = b.r - a.l; dy = b.b - a.t;
      return dx > dy ? aabbcr_pkg::DIR_TOP :
             (dx < dy ? aabbcr_pkg::DIR_LEFT : aabbcr_pkg::DIR_TOP_LEFT);
    end
    if (o.r < b.r && b.t < o.t) begin
      if (b.l <= o.r) return aabbcr_pkg::DIR_TOP;
      if (o.t <= b.b) return aabbcr_pkg::DIR_RIGHT;
      dx = a.r - b.l; dy = b.b - a.t;
      return dx > dy ? aabbcr_pkg::DIR_TOP :
             (dx < dy ? aabbcr_pkg::DIR_RIGHT : aabbcr_pkg::DIR_TOP_RIGHT);
    end
    if (b.l < o.l && o.b < b.b) begin
      if (o.l <= b.r) return aabbcr_pkg::DIR_BOTTOM;
      if (b.t <= o.b) return aabbcr_pkg::DIR_LEFT;
      dx = b.r - a.l; dy = a.b - b.t;
      return dx > dy ? aabbcr_pkg::DIR_BOTTOM :
             (dx < dy ? aabbcr_pkg::DIR_LEFT : aabbcr_pkg::DIR_BOTTOM_LEFT);
    end
    if (o.r < b.r && o.b < b.b) begin
      if (b.l <= o.r) return aabbcr_pkg::DIR_BOTTOM;
      if (b.t <= o.b) return aabbcr_pkg::DIR_RIGHT;
      dx = a.r - b.l; dy = a.b - b.t;
      return dx > dy ? aabbcr_pkg::DIR_BOTTOM :
             (dx < dy ? aabbcr_pkg::DIR_RIGHT : aabbcr_pkg::DIR_BOTTOM_RIGHT);
    end
    return aabbcr_pkg::DIR_NONE;
  endfunction

  // B's share of a penetration; A gets the remainder plus the margin.
  function automatic longint b_share(longint pen, longint f, longint r);
    longint d;
    if (f <= r) return 0;
    d = f + r;
    return (pen / d) * f + ((pen % d) * f) / d;
  endfunction

  function automatic logic [CB:0] clip(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< CB) - 1;
    lo = -(longint'(1) <<< CB);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CB:0];
  endfunction

  function automatic push_t resolve();
    rect_t            a, o, b;
    longint           f, r, pen, bs, ax, ay, bx, by, mx, my;
    aabbcr_pkg::dir_t d;
    push_t            p;
    a.l = longint'(pair.a_left);  a.t = longint'(pair.a_top);
    a.r = a.l + longint'({1'b0, pair.a_width});
    a.b = a.t + longint'({1'b0, pair.a_height});
    mx = longint'(pair.a_move_x); my = longint'(pair.a_move_y);
    o.l = a.l - mx; o.r = a.r - mx; o.t = a.t - my; o.b = a.b - my;
    b.l = longint'(pair.b_left);  b.t = longint'(pair.b_top);
    b.r = b.l + longint'({1'b0, pair.b_width});
    b.b = b.t + longint'({1'b0, pair.b_height});
    f = longint'({1'b0, pair.push_force});
    r = longint'({1'b0, pair.b_resistance});
    d = hit_dir(a, o, b);
    ax = 0; ay = 0; bx = 0; by = 0;
    if (d inside {aabbcr_pkg::DIR_TOP, aabbcr_pkg::DIR_TOP_LEFT,
                  aabbcr_pkg::DIR_TOP_RIGHT}) begin
      pen = b.b - a.t; if (pen < 0) pen = 0;
      bs = b_share(pen, f, r); ay = pen - bs + margin; by = -bs;
    end else if (d inside {aabbcr_pkg::DIR_BOTTOM, aabbcr_pkg::DIR_BOTTOM_LEFT,
                           aabbcr_pkg::DIR_BOTTOM_RIGHT}) begin
      pen = a.b - b.t; if (pen < 0) pen = 0;
      bs = b_share(pen, f, r); ay = -(pen - bs + margin); by = bs;
    end
    if (d inside {aabbcr_pkg::DIR_LEFT, aabbcr_pkg::DIR_TOP_LEFT,
                  aabbcr_pkg::DIR_BOTTOM_LEFT}) begin
      pen = b.r - a.l; if (pen < 0) pen = 0;
      bs = b_share(pen, f, r); ax = pen - bs + margin; bx = -bs;
    end else if (d inside {aabbcr_pkg::DIR_RIGHT, aabbcr_pkg::DIR_TOP_RIGHT,
                           aabbcr_pkg::DIR_BOTTOM_RIGHT}) begin
      pen = a.r - b.l; if (pen < 0) pen = 0;
      bs = b_share(pen, f, r); ax = -(pen - bs + margin); bx = bs;
    end
    p.dir = d; p.ax = clip(ax); p.ay = clip(ay); p.bx = clip(bx); p.by = clip(by);
    return p;
  endfunction

  always @(posedge clk) begin
    push_t want, got;
    if (rst) begin
      margin <= aabbcr_pkg::MARGIN_RESET;
      fails  <= 0;
      push_q.delete();
    end else begin
      if (cfg_we) margin <= cfg_wdata;
      if (pair.valid && pair.ready) push_q.push_back(resolve());
      if (res.valid && res.ready) begin
        got = {res.direction, res.a_shift_x, res.a_shift_y, res.b_shift_x,
               res.b_shift_y};
        if (push_q.size() == 0) begin
          fails <= fails + 1;
          if (fails < 10) $display("unexpected result item %h", got);
        end else begin
          want = push_q.pop_front();
          if (want !== got) begin
            fails <= fails + 1;
            if (fails < 10)
              $display("mismatch: dir %0d/%0d ax %0d/%0d ay %0d/%0d bx %0d/%0d by %0d/%0d",
                       want.dir, got.dir, $signed(want.ax), $signed(got.ax),
                       $signed(want.ay), $signed(got.ay), $signed(want.bx),
                       $signed(got.bx), $signed(want.by), $signed(got.by));
          end
        end
      end
    end
  end
endmodule

// ===== bench/aabb_collision_push_resolve_core_tb.sv =====
// ----------------------------------------------------------------------------
// aabb_collision_push_resolve_core_tb
// Drives directed and random box pairs through the resolver under several
// margins and idling mixes, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module aabb_collision_push_resolve_core_tb;

  localparam int CB = 24;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [aabbcr_pkg::MARGIN_W-1:0] cfg_wdata = '0;
  int   fails, pending;

  // Percent of cycles that the sender and the receiver sit idle.
  int   send_idle = 0;
  int   recv_idle = 0;
  // Set while the receiver is held off for a long stretch.
  bit   recv_hold = 0;

  aabbcr_pair_if #(.COORD_BITS(CB)) pair ();
  aabbcr_res_if  #(.COORD_BITS(CB)) res ();

  aabb_collision_push_resolve_core #(.COORD_BITS(CB)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pair(pair), .res(res)
  );

  aabb_collision_push_resolve_core_chk #(.CB(CB)) chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pair(pair), .res(res), .fails(fails), .pending(pending)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // The receiver stalls at random unless a long hold-off is in force.
  always @(posedge clk) begin
    res.ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
  end

  // Random 24-bit value, usually small, sometimes at the extremes.
  function automatic logic [CB-1:0] pick_coord(int span);
    case ($urandom_range(9))
      0:       return {1'b0, {(CB-1){1'b1}}};
      1:       return {1'b1, {(CB-1){1'b0}}};
      2:       return CB'($urandom);
      default: return CB'($signed($urandom_range(2 * span)) - span);
    endcase
  endfunction

  function automatic logic [CB-2:0] pick_size(int span);
    case ($urandom_range(9))
      0:       return '1;
      1:       return '0;
      2:       return (CB-1)'($urandom);
      default: return (CB-1)'($urandom_range(span));
    endcase
  endfunction

  // Presents one item and holds it until the block accepts it. Valid stays
  // high afterwards, so the caller offers again or drains in the same step.
  task automatic offer(input logic [CB-1:0] al, at, input logic [CB-2:0] aw, ah,
                       input logic [CB-1:0] mx, my, bl, bt,
                       input logic [CB-2:0] bw, bh, input logic [15:0] f, r);
    while ($urandom_range(99) < send_idle) begin
      pair.valid <= 0;
      @(posedge clk);
    end
    pair.valid <= 1;
    pair.a_left <= al; pair.a_top <= at; pair.a_width <= aw; pair.a_height <= ah;
    pair.a_move_x <= mx; pair.a_move_y <= my; pair.b_left <= bl; pair.b_top <= bt;
    pair.b_width <= bw; pair.b_height <= bh; pair.push_force <= f;
    pair.b_resistance <= r;
    @(posedge clk);
    while (!pair.ready) @(posedge clk);
  endtask

  // A pair aimed at a hit: A touches or overlaps B, and its move is random.
  task automatic offer_hit();
    int s;
    logic [CB-1:0] bl, bt, al, at;
    logic [CB-2:0] aw, ah, bw, bh;
    logic [15:0] f, r;
    s  = $urandom_range(3) == 0 ? 60000 : 400;
    bl = CB'($urandom_range(2000) - 1000);
    bt = CB'($urandom_range(2000) - 1000);
    bw = (CB-1)'($urandom_range(s)); bh = (CB-1)'($urandom_range(s));
    aw = (CB-1)'($urandom_range(s)); ah = (CB-1)'($urandom_range(s));
    al = CB'(bl + $urandom_range(bw + aw) - aw);
    at = CB'(bt + $urandom_range(bh + ah) - ah);
    f  = $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom);
    r  = $urandom_range(2) == 0 ? f : 16'($urandom);
    offer(al, at, aw, ah, CB'($signed($urandom_range(2 * s)) - s),
          CB'($signed($urandom_range(2 * s)) - s), bl, bt, bw, bh, f, r);
  endtask

  task automatic offer_noise();
    offer(pick_coord(5000), pick_coord(5000), pick_size(3000), pick_size(3000),
          pick_coord(5000), pick_coord(5000), pick_coord(5000), pick_coord(5000),
          pick_size(3000), pick_size(3000), 16'($urandom), 16'($urandom));
  endtask

  // Stops offering and waits until every expected result has come; the count
  // is read between edges, then the task returns on a rising edge.
  task automatic drain();
    pair.valid <= 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_margin(input logic [aabbcr_pkg::MARGIN_W-1:0] m);
    cfg_we <= 1; cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    pair.valid <= 0;
    pair.a_left <= '0; pair.a_top <= '0; pair.a_width <= '0; pair.a_height <= '0;
    pair.a_move_x <= '0; pair.a_move_y <= '0; pair.b_left <= '0; pair.b_top <= '0;
    pair.b_width <= '0; pair.b_height <= '0; pair.push_force <= '0;
    pair.b_resistance <= '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: box B at 100..200 on both axes.
    // A moved down into B from above: a pure bottom hit, weak push.
    offer(80, 40, 40, 70, 0, 20, 100, 100, 100, 100, 5, 9);
    // Same bottom hit with a strong push so that B moves too.
    offer(80, 40, 40, 70, 0, 20, 100, 100, 100, 100, 9, 5);
    // A moved up into B from below, and from left and right.
    offer(120, 190, 20, 40, 0, -20, 100, 100, 100, 100, 1, 0);
    offer(190, 120, 40, 20, -20, 0, 100, 100, 100, 100, 0, 0);
    offer(50, 120, 60, 20, 20, 0, 100, 100, 100, 100, 65535, 65535);
    // Diagonal entry with equal depths gives each of the four corners.
    offer(90, 90, 20, 20, 20, 20, 100, 100, 100, 100, 3, 1);
    offer(190, 90, 20, 20, -20, 20, 100, 100, 100, 100, 3, 1);
    offer(90, 190, 20, 20, 20, -20, 100, 100, 100, 100, 3, 1);
    offer(190, 190, 20, 20, -20, -20, 100, 100, 100, 100, 3, 1);
    // Diagonal entry with unequal depths breaks toward one side.
    offer(85, 95, 20, 20, 20, 20, 100, 100, 100, 100, 65535, 0);
    offer(95, 85, 20, 20, 20, 20, 100, 100, 100, 100, 65535, 0);
    // No hit: already overlapping before, and far apart.
    offer(120, 120, 20, 20, 1, 1, 100, 100, 100, 100, 1, 1);
    offer(-8388608, -8388608, 10, 10, 0, 0, 100, 100, 100, 100, 1, 1);
    // Edges touching count as inside.
    offer(60, 120, 40, 20, 10, 0, 100, 100, 100, 100, 1, 1);
    // Field extremes, large boxes, shift saturation.
    offer(24'h7FFFFF, 24'h7FFFFF, '1, '1, 24'h800000, 24'h800000,
          24'h800000, 24'h800000, '1, '1, 16'hFFFF, 16'h0000);
    offer(24'h800000, 24'h800000, '1, '1, 24'h7FFFFF, 24'h7FFFFF,
          24'h800000, 24'h800000, '1, '1, 16'hFFFF, 16'hFFFE);
    offer(24'h800000, 24'h000000, '1, 0, 24'h000000, 24'h7FFFFF,
          24'h7FFFFF, 24'h800000, '1, '1, 0, 16'hFFFF);
    drain();

    // Phases over margins and idling mixes; margins written while idle.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_margin(8'd0);
        1: set_margin(8'd255);
        2: set_margin(aabbcr_pkg::MARGIN_W'($urandom));
        3: set_margin(8'd1);
        4: set_margin(8'd128);
        default: set_margin(aabbcr_pkg::MARGIN_W'($urandom));
      endcase
      send_idle = ph < 2 ? 16 : (ph < 4 ? 46 : 0);
      recv_idle = ph < 2 ? 46 : (ph < 4 ? 16 : 0);
      for (int i = 0; i < 322; i++) begin
        if (i == 100 && ph == 4) fork
          begin
            recv_hold = 1;
            repeat (200) @(posedge clk);
            recv_hold = 0;
          end
        join_none
        // The sender also waits for every result partway through each phase.
        if (i == 200) drain();
        if ($urandom_range(3) == 0) offer_noise();
        else offer_hit();
      end
      drain();
    end

    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/aabbcr_pkg.sv
rtl/aabbcr_if.sv
rtl/aabbcr_div.sv
rtl/aabb_collision_push_resolve_core.sv
bench/aabb_collision_push_resolve_core_chk.sv
bench/aabb_collision_push_resolve_core_tb.sv
